@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int ALIGN_BYTES  = 8;
  localparam int MIN_SPLIT    = 8;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic [3:0] REG_HEAP_START = 4'd0;
  localparam logic [3:0] REG_HEAP_BYTES = 4'd8;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic [47:0] release_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] payload_address;
    logic [31:0] free_bytes;
  } res_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake                  | payload
// cmd      | in        | cmd_valid / cmd_stall      | operation, request_size, release_address
// res      | out       | res_valid / res_stall      | status, payload_address, free_bytes
// apb      | in        | psel/penable/pwrite/pready | heap_start @0, heap_bytes @8
// one item at a time; the table sits in a single-port-read ram, each entry visit is a read
// state then an evaluate state, an allocation scans and on a split shifts later entries up
// (read, then write each), and a release scans, then walks all entries to merge free ones
// reset empties the table; a configuration write while idle rebuilds it in the same cycle
// a result waiting under res_stall holds the sequencer in its last state
module first_fit_heap_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire ffha_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output ffha_pkg::res_t     res,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_EV, S_SH_RD, S_SH_WR, S_A_REST, S_A_HEAD,
    S_R_RD, S_R_EV, S_M_RD, S_M_EV, S_M_LAST, S_DONE
  } state_t;

  state_t            state;
  logic [47:0]       heap_start;
  logic [31:0]       heap_bytes;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       total;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  hit;
  logic [IDX_W-1:0]  wptr;
  logic [32:0]       rsize;
  logic [47:0]       rel_addr;
  logic              split;
  logic              first;
  entry_t            acc;
  logic [1:0]        status;
  logic [47:0]       pay;

  logic              cfg_we;
  logic [31:0]       hb_new;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            rd;
  entry_t            rdm;
  logic              last;
  logic [47:0]       rd_pay;
  logic [32:0]       rsize_in;

  assign pready    = 1'b1;
  assign cmd_stall = (state != S_IDLE) || cfg_we;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign hb_new    = paddr[3] ? pwdata[31:0] : heap_bytes;
  assign prdata    = paddr[3] ? {32'b0, heap_bytes} : {16'b0, heap_start};
  assign last      = ({1'b0, idx} + CNT_W'(1)) == cnt;
  assign rd_pay    = heap_start + {16'b0, rd.offset} + 48'(HEADER_BYTES);
  assign rsize_in  = 33'((({1'b0, cmd.request_size} + 33'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                     * ALIGN_BYTES);

  always_comb begin
    rdm = rd;
    if (idx == hit) begin
      rdm.is_free = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = acc;
    ram_raddr = idx;
    case (state)
      S_IDLE: begin
        ram_we    = cfg_we && (hb_new >= 32'(HEADER_BYTES));
        ram_waddr = '0;
        ram_wdata = '{offset: 32'd0, size: hb_new - 32'(HEADER_BYTES), is_free: 1'b1};
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx + IDX_W'(1);
        ram_wdata = rd;
      end
      S_A_REST: begin
        ram_we    = 1'b1;
        ram_waddr = hit + IDX_W'(1);
        ram_wdata = '{offset: acc.offset + 32'(HEADER_BYTES) + rsize[31:0],
                      size: acc.size - rsize[31:0] - 32'(HEADER_BYTES), is_free: 1'b1};
      end
      S_A_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = hit;
        ram_wdata = '{offset: acc.offset, size: split ? rsize[31:0] : acc.size,
                      is_free: 1'b0};
      end
      S_M_EV: begin
        ram_we    = !first && !(acc.is_free && rdm.is_free);
        ram_waddr = wptr;
        ram_wdata = acc;
      end
      S_M_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = wptr;
        ram_wdata = acc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      heap_start <= '0;
      heap_bytes <= '0;
      cnt        <= '0;
      total      <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            if (paddr[3]) begin
              heap_bytes <= pwdata[31:0];
            end else begin
              heap_start <= pwdata[47:0];
            end
            if (hb_new >= 32'(HEADER_BYTES)) begin
              cnt   <= CNT_W'(1);
              total <= hb_new - 32'(HEADER_BYTES);
            end else begin
              cnt   <= '0;
              total <= '0;
            end
          end else if (cmd_valid) begin
            idx      <= '0;
            hit      <= '1;
            rsize    <= rsize_in;
            rel_addr <= cmd.release_address;
            pay      <= '0;
            split    <= 1'b0;
            if (cmd.operation == OP_ALLOC) begin
              status <= ST_NOFIT;
              state  <= (cnt == '0) ? S_DONE : S_A_RD;
            end else begin
              status <= (cmd.release_address == '0) ? ST_OK : ST_BADADDR;
              state  <= (cnt == '0) ? S_DONE : S_R_RD;
            end
          end
        end
        S_A_RD: state <= S_A_EV;
        S_A_EV: begin
          if (rd.is_free && ({1'b0, rd.size} >= rsize)) begin
            acc <= rd;
            hit <= idx;
            if ((cnt < CNT_W'(MAX_BLOCKS)) &&
                ({2'b0, rd.size} >= {1'b0, rsize} + 34'(HEADER_BYTES + MIN_SPLIT))) begin
              split <= 1'b1;
              if (last) begin
                state <= S_A_REST;
              end else begin
                idx   <= IDX_W'(cnt - CNT_W'(1));
                state <= S_SH_RD;
              end
            end else begin
              state <= S_A_HEAD;
            end
          end else if (last) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_A_RD;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (idx == hit + IDX_W'(1)) begin
            state <= S_A_REST;
          end else begin
            idx   <= idx - IDX_W'(1);
            state <= S_SH_RD;
          end
        end
        S_A_REST: begin
          cnt   <= cnt + CNT_W'(1);
          total <= total - rsize[31:0] - 32'(HEADER_BYTES);
          state <= S_A_HEAD;
        end
        S_A_HEAD: begin
          if (!split) begin
            total <= total - acc.size;
          end
          pay    <= heap_start + {16'b0, acc.offset} + 48'(HEADER_BYTES);
          status <= ST_OK;
          state  <= S_DONE;
        end
        S_R_RD: state <= S_R_EV;
        S_R_EV: begin
          if (rd_pay == rel_addr) begin
            hit    <= idx;
            status <= ST_OK;
            if (!rd.is_free) begin
              total <= total + rd.size;
            end
            idx   <= '0;
            first <= 1'b1;
            wptr  <= '0;
            state <= S_M_RD;
          end else if (last) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_R_RD;
          end
        end
        S_M_RD: state <= S_M_EV;
        S_M_EV: begin
          first <= 1'b0;
          if (first) begin
            acc <= rdm;
          end else if (acc.is_free && rdm.is_free) begin
            acc.size <= acc.size + 32'(HEADER_BYTES) + rdm.size;
            total    <= total + 32'(HEADER_BYTES);
          end else begin
            wptr <= wptr + IDX_W'(1);
            acc  <= rdm;
          end
          if (last) begin
            state <= S_M_LAST;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_M_RD;
          end
        end
        S_M_LAST: begin
          cnt   <= {1'b0, wptr} + CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res       <= '{status: status, payload_address: pay, free_bytes: total};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ST_OK) |-> (res.payload_address == '0))
    else $error("failed item carries an address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && !cfg_we |=> (state != S_IDLE))
    else $error("accepted item left sequencer idle");

endmodule
`default_nettype wire

@@ rtl/ffha_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
